FILE: hw/rtl/md2_pkg.sv
// Shared types, constants and the S-box table for the MD2 digest block.
`default_nettype none

package md2_pkg;

  localparam int BLK_LEN  = 16;
  localparam int WORK_LEN = 'h30;
  localparam int ROUNDS   = 18;

  localparam logic [7:0] SBOX [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

  typedef logic [BLK_LEN-1:0][7:0] md2_block_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mix_ctrl_t;

  typedef enum logic [1:0] {
    MX_IDLE,
    MX_CSUM,
    MX_ROUND
  } mx_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_MIX,
    ST_EMIT
  } top_state_t;

  function automatic logic [7:0] md2_sbox(input logic [7:0] idx);
    return SBOX[idx];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/md2_stream_if.sv
// Valid/ready channel interfaces for message words and digest words.
`default_nettype none

interface md2_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source(output valid, output mode, output data_byte, input ready);
  modport sink(input valid, input mode, input data_byte, output ready);
endinterface

interface md2_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;
  logic [3:0] byte_position;
  logic       last_byte;

  modport source(output valid, output digest_byte, output byte_position, output last_byte,
                 input ready);
  modport sink(input valid, input digest_byte, input byte_position, input last_byte,
               output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/md2_mixer.sv
// Block mixer: one shared S-box step per cycle over checksum and 48-byte work line.
`default_nettype none

module md2_mixer (
  input  logic               clk,
  input  logic               rst,
  input  md2_pkg::mix_ctrl_t ctrl,
  input  md2_pkg::md2_block_t blk,
  output md2_pkg::md2_block_t chain,
  output md2_pkg::md2_block_t checksum,
  output logic               done
);
  import md2_pkg::*;

  logic [7:0] w [WORK_LEN];
  mx_phase_t  phase, phase_next;
  logic [5:0] k;
  logic [4:0] r;
  logic [7:0] t;
  logic [7:0] sb_idx;
  logic [7:0] sb_out;
  logic [7:0] mixed;
  logic       csum_last;
  logic       step_last;
  logic       round_last;

  assign csum_last  = (k == 6'(BLK_LEN - 1));
  assign step_last  = (k == 6'(WORK_LEN - 1));
  assign round_last = (r == 5'(ROUNDS - 1));

  always_comb begin
    phase_next = phase;
    case (phase)
      MX_IDLE:  if (ctrl.start) phase_next = MX_CSUM;
      MX_CSUM:  if (csum_last) phase_next = MX_ROUND;
      MX_ROUND: if (step_last && round_last) phase_next = MX_IDLE;
      default:  phase_next = MX_IDLE;
    endcase
  end

  always_comb begin
    if (phase == MX_CSUM) begin
      sb_idx = blk[k[3:0]] ^ t;
    end else begin
      sb_idx = t;
    end
    sb_out = md2_sbox(sb_idx);
    mixed  = ((phase == MX_CSUM) ? checksum[0] : w[0]) ^ sb_out;
    done   = (phase == MX_ROUND) && step_last && round_last;
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      for (int i = 0; i < BLK_LEN; i++) begin
        w[i]             <= chain[i];
        w[i + BLK_LEN]   <= blk[i];
        w[i + 2*BLK_LEN] <= blk[i] ^ chain[i];
      end
    end else if (phase == MX_ROUND) begin
      for (int i = 0; i < WORK_LEN - 1; i++) begin
        w[i] <= w[i + 1];
      end
      w[WORK_LEN-1] <= mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= MX_IDLE;
      k        <= '0;
      r        <= '0;
      t        <= '0;
      chain    <= '0;
      checksum <= '0;
    end else begin
      phase <= phase_next;
      if (ctrl.clear) begin
        chain    <= '0;
        checksum <= '0;
      end
      case (phase)
        MX_IDLE: begin
          if (ctrl.start) begin
            t <= checksum[BLK_LEN-1];
            k <= '0;
          end
        end
        MX_CSUM: begin
          for (int i = 0; i < BLK_LEN - 1; i++) begin
            checksum[i] <= checksum[i + 1];
          end
          checksum[BLK_LEN-1] <= mixed;
          if (csum_last) begin
            k <= '0;
            r <= '0;
            t <= '0;
          end else begin
            k <= k + 6'd1;
            t <= mixed;
          end
        end
        MX_ROUND: begin
          if (step_last) begin
            k <= '0;
            t <= mixed + {3'b000, r};
            r <= r + 5'd1;
            if (round_last) begin
              for (int i = 0; i < BLK_LEN; i++) begin
                chain[i] <= w[i + 1];
              end
            end
          end else begin
            k <= k + 6'd1;
            t <= mixed;
          end
        end
        default: k <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/md2_message_digest_top.sv
// MD2 digest top level: word gathering, padding, sequencing and digest output.
// Usage:
//   msg channel: mode 0 carries one message byte in data_byte; mode 1 ends
//   the message. digest channel: after a finish word, 16 words carry the
//   digest, first byte first, byte_position 0..15, last_byte on the last.
// Timing:
//   The 16th byte of a block starts a mix (one load, the checksum pass,
//   then 18 rounds of 48 steps), during which ready is low.
//   The mix length is set by the single S-box lookup in the mixer, one
//   dependent step per cycle.
//   A finish word pads the block with (16 - bytes in block) bytes, runs two
//   mixes (the padded block, then the checksum), then sends the 16 digest
//   words at up to one per cycle.
// Reset clears chain state, checksum and fill count; an empty message then
//   digests as the empty string. These also clear after the last digest word.
// A stalled digest receiver holds the current word; no new word is taken
//   until the whole digest has gone out.
`default_nettype none

module md2_message_digest_top (
  input logic      clk,
  input logic      rst,
  md2_in_if.sink   msg,
  md2_out_if.source digest
);
  import md2_pkg::*;

  top_state_t state, state_next;
  md2_block_t blk_buf;
  md2_block_t chain;
  md2_block_t checksum;
  mix_ctrl_t  ctrl;
  logic       done;
  logic [3:0] fill;
  logic [3:0] pos;
  logic [7:0] pad_val;
  logic       finishing;
  logic       ck_pass;
  logic       in_fire;
  logic       out_fire;
  logic       fill_last;
  logic       pos_last;

  md2_mixer u_mixer (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .blk      (blk_buf),
    .chain    (chain),
    .checksum (checksum),
    .done     (done)
  );

  assign in_fire   = msg.valid && msg.ready;
  assign out_fire  = digest.valid && digest.ready;
  assign fill_last = (fill == 4'(BLK_LEN - 1));
  assign pos_last  = (pos == 4'(BLK_LEN - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (msg.mode) begin
            state_next = ST_PAD;
          end else if (fill_last) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_PAD: if (fill_last) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_MIX;
      ST_MIX: begin
        if (done) begin
          if (!finishing) begin
            state_next = ST_IDLE;
          end else if (!ck_pass) begin
            state_next = ST_LOAD;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: if (out_fire && pos_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    msg.ready            = (state == ST_IDLE);
    ctrl.start           = (state == ST_LOAD);
    ctrl.clear           = out_fire && pos_last;
    digest.valid         = (state == ST_EMIT);
    digest.digest_byte   = chain[pos];
    digest.byte_position = pos;
    digest.last_byte     = pos_last;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire) begin
      if (!msg.mode) begin
        for (int i = 0; i < BLK_LEN - 1; i++) begin
          blk_buf[i] <= blk_buf[i + 1];
        end
        blk_buf[BLK_LEN-1] <= msg.data_byte;
      end else begin
        pad_val <= 8'(5'(BLK_LEN) - {1'b0, fill});
      end
    end else if (state == ST_PAD) begin
      for (int i = 0; i < BLK_LEN - 1; i++) begin
        blk_buf[i] <= blk_buf[i + 1];
      end
      blk_buf[BLK_LEN-1] <= pad_val;
    end else if (state == ST_MIX && done && finishing && !ck_pass) begin
      blk_buf <= checksum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      pos       <= '0;
      finishing <= 1'b0;
      ck_pass   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (msg.mode) begin
              finishing <= 1'b1;
            end else begin
              fill <= fill + 4'd1;
            end
          end
        end
        ST_PAD: fill <= fill + 4'd1;
        ST_MIX: begin
          if (done && finishing) begin
            if (!ck_pass) begin
              ck_pass <= 1'b1;
            end else begin
              pos <= '0;
            end
          end
        end
        ST_EMIT: begin
          if (out_fire) begin
            pos <= pos + 4'd1;
            if (pos_last) begin
              finishing <= 1'b0;
              ck_pass   <= 1'b0;
              fill      <= '0;
            end
          end
        end
        default: pos <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the MD2 digest top level with its own digest predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;
  localparam int   CYCLE_LIMIT = 4000000;
  localparam int   DRAIN_CYCLES = 100;
  localparam int   MAX_GAP = 60;
  localparam int   PHASE_WORDS = 80;

  localparam logic [7:0] SBOX_TBL [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

  typedef logic [15:0][7:0] byte_blk_t;

  typedef struct packed {
    logic [7:0] dbyte;
    logic [3:0] pos;
    logic       last;
  } digest_word_t;

  typedef struct packed {
    logic         mode;
    logic [7:0]   data;
    logic         known;
    logic [127:0] digest;
  } stim_row_t;

  localparam int DIR_LEN = 24;
  localparam stim_row_t DIR_ROWS [DIR_LEN] = '{
    '{MODE_FINISH, 8'h00, 1'b1, 128'h8350e5a3e24c153df2275c9f80692773},
    '{MODE_ABSORB, 8'h61, 1'b0, 128'h0},
    '{MODE_FINISH, 8'hff, 1'b1, 128'h32ec01ec4a6dac72c0ab96fb34c0b5d1},
    '{MODE_ABSORB, 8'h61, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'h62, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'h63, 1'b0, 128'h0},
    '{MODE_FINISH, 8'h5a, 1'b1, 128'hda853b0d3f88d99b30283a69e6ded6bb},
    '{MODE_ABSORB, 8'h00, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'hff, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'h01, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'h80, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'h7f, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'hfe, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'h10, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'hef, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'h55, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'haa, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'h3c, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'hc3, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'h0f, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'hf0, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'h96, 1'b0, 128'h0},
    '{MODE_ABSORB, 8'h69, 1'b0, 128'h0},
    '{MODE_FINISH, 8'h00, 1'b0, 128'h0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  md2_in_if  msg ();
  md2_out_if digest ();

  md2_message_digest_top dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .digest (digest)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_blk_t    chain_q;
  byte_blk_t    csum_q;
  byte_blk_t    blk_q;
  logic [3:0]   fill_q;
  digest_word_t pending_digest [$];
  int           n_mismatch = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           words_sent = 0;
  int           cycle_cnt = 0;

  function automatic void md2_mix_block(input byte_blk_t blk);
    logic [47:0][7:0] w;
    logic [7:0]       t;
    int               r;
    int               k;
    for (k = 0; k < 16; k++) begin
      w[k]      = chain_q[k];
      w[k + 16] = blk[k];
      w[k + 32] = blk[k] ^ chain_q[k];
    end
    t = 8'h00;
    for (r = 0; r < 18; r++) begin
      for (k = 0; k < 48; k++) begin
        w[k] = w[k] ^ SBOX_TBL[t];
        t    = w[k];
      end
      t = 8'(t + r);
    end
    for (k = 0; k < 16; k++) chain_q[k] = w[k];
    t = csum_q[15];
    for (k = 0; k < 16; k++) begin
      csum_q[k] = csum_q[k] ^ SBOX_TBL[blk[k] ^ t];
      t         = csum_q[k];
    end
  endfunction

  task automatic md2_track_word(input logic mode, input logic [7:0] b,
                                output logic done, output logic [127:0] dig);
    int i;
    done = 1'b0;
    dig  = '0;
    if (mode == MODE_ABSORB) begin
      blk_q[fill_q] = b;
      if (fill_q == 4'd15) begin
        md2_mix_block(blk_q);
        fill_q = 4'd0;
      end else begin
        fill_q = fill_q + 4'd1;
      end
    end else begin
      for (i = fill_q; i < 16; i++) blk_q[i] = 8'(16 - fill_q);
      md2_mix_block(blk_q);
      md2_mix_block(csum_q);
      for (i = 0; i < 16; i++) dig[127 - 8 * i -: 8] = chain_q[i];
      chain_q = '0;
      csum_q  = '0;
      fill_q  = 4'd0;
      done    = 1'b1;
    end
  endtask

  task automatic send_word(input logic mode, input logic [7:0] b,
                           input logic known, input logic [127:0] known_dig);
    int           gap;
    int           i;
    logic         done;
    logic [127:0] dig;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      msg.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg.valid     <= 1'b1;
    msg.mode      <= mode;
    msg.data_byte <= b;
    @(posedge clk);
    while (!msg.ready) @(posedge clk);
    words_sent++;
    md2_track_word(mode, b, done, dig);
    if (done) begin
      if (known) dig = known_dig;
      for (i = 0; i < 16; i++)
        pending_digest.push_back('{dig[127 - 8 * i -: 8], 4'(i), i == 15});
    end
  endtask

  task automatic send_message();
    int len;
    int j;
    len = ($urandom_range(7) == 0) ? $urandom_range(48, 17) : $urandom_range(16, 0);
    for (j = 0; j < len; j++) send_word(MODE_ABSORB, 8'($urandom_range(255)), 1'b0, '0);
    send_word(MODE_FINISH, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  task automatic run_phase(input int idle, input int stall);
    int phase_end;
    idle_pct  = idle;
    stall_pct = stall;
    phase_end = words_sent + PHASE_WORDS;
    while (words_sent < phase_end) send_message();
  endtask

  always @(posedge clk) begin
    digest.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    digest_word_t want;
    if (!rst && digest.valid && digest.ready) begin
      if (pending_digest.size() == 0) begin
        $display("%0t: unexpected digest word: expected none, actual byte %h pos %0d last %b",
                 $time, digest.digest_byte, digest.byte_position, digest.last_byte);
        n_mismatch++;
      end else begin
        want = pending_digest.pop_front();
        if (digest.digest_byte !== want.dbyte) begin
          $display("%0t: digest_byte mismatch: expected %h actual %h",
                   $time, want.dbyte, digest.digest_byte);
          n_mismatch++;
        end
        if (digest.byte_position !== want.pos) begin
          $display("%0t: byte_position mismatch: expected %0d actual %0d",
                   $time, want.pos, digest.byte_position);
          n_mismatch++;
        end
        if (digest.last_byte !== want.last) begin
          $display("%0t: last_byte mismatch: expected %b actual %b",
                   $time, want.last, digest.last_byte);
          n_mismatch++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int n;
    msg.valid     <= 1'b0;
    msg.mode      <= MODE_ABSORB;
    msg.data_byte <= 8'h00;
    chain_q = '0;
    csum_q  = '0;
    blk_q   = '0;
    fill_q  = 4'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < DIR_LEN; n++)
      send_word(DIR_ROWS[n].mode, DIR_ROWS[n].data, DIR_ROWS[n].known, DIR_ROWS[n].digest);

    run_phase(0, 0);
    run_phase(67, 0);
    run_phase(0, 67);
    run_phase(25, 25);
    msg.valid <= 1'b0;

    while (pending_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_mismatch == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/md2_pkg.sv
hw/rtl/md2_stream_if.sv
hw/rtl/md2_mixer.sv
hw/rtl/md2_message_digest_top.sv
tb/tb_top.sv
